[rtl/stf_pkg.sv]
package stf_pkg;

    localparam int IN_W   = 16;
    localparam int SUM_W  = 24;
    localparam int SQ_W   = 40;
    localparam int PRD_W  = 32;
    localparam int LO_W   = 24;
    localparam int OPA_W  = 25;
    localparam int MUL_W  = 50;
    localparam int ACC_W  = 62;
    localparam int DEN_W  = 46;
    localparam int REM_W  = 48;
    localparam int DVD_W  = 78;
    localparam int IT_W   = 7;
    localparam int Q_W    = 33;
    localparam int COS_W  = 24;
    localparam int SH_W   = 32;
    localparam int CNT_W  = 5;
    localparam int PROD_STEPS  = 6;
    localparam int SOLVE_STEPS = 24;
    localparam int DIV_COUNT   = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SOLVE,
        S_DIV,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        A_S2_LO,
        A_S2_HI,
        A_SD_LO,
        A_SD_HI,
        A_SC_LO,
        A_SC_HI,
        A_SX,
        A_SY
    } t_asel;

    typedef enum logic [2:0] {
        B_N,
        B_SX,
        B_SY,
        B_SU,
        B_SV
    } t_bsel;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_DET,
        ST_NA,
        ST_NB,
        ST_NX,
        ST_NY
    } t_store;

    typedef enum logic [1:0] {
        PB_X,
        PB_Y,
        PB_U,
        PB_V
    } t_pb;

    typedef enum logic [1:0] {
        PT_NORM,
        PT_DOT,
        PT_CROSS
    } t_ptgt;

    typedef enum logic [1:0] {
        D_COS,
        D_SIN,
        D_SHX,
        D_SHY
    } t_didx;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   sub;
        logic   first;
        t_store store;
    } t_mac_op;

    typedef struct packed {
        logic  a_y;
        t_pb   b_sel;
        t_ptgt tgt;
        logic  sub;
    } t_prod_op;

    typedef struct packed {
        logic        load;
        logic        prod_en;
        logic [2:0]  prod_idx;
        logic        mac_en;
        logic [4:0]  mac_step;
        logic        div_start;
        t_didx       div_idx;
        logic        out_load;
    } t_cmd;

    typedef struct packed {
        logic det_pos;
        logic div_done;
    } t_status;

    function automatic t_prod_op prod_op(input logic [2:0] idx);
        t_prod_op op;
        case (idx)
            3'd0:    op = '{a_y: 1'b0, b_sel: PB_X, tgt: PT_NORM,  sub: 1'b0};
            3'd1:    op = '{a_y: 1'b1, b_sel: PB_Y, tgt: PT_NORM,  sub: 1'b0};
            3'd2:    op = '{a_y: 1'b0, b_sel: PB_U, tgt: PT_DOT,   sub: 1'b0};
            3'd3:    op = '{a_y: 1'b1, b_sel: PB_V, tgt: PT_DOT,   sub: 1'b0};
            3'd4:    op = '{a_y: 1'b0, b_sel: PB_V, tgt: PT_CROSS, sub: 1'b0};
            3'd5:    op = '{a_y: 1'b1, b_sel: PB_U, tgt: PT_CROSS, sub: 1'b1};
            default: op = '{a_y: 1'b0, b_sel: PB_X, tgt: PT_NORM,  sub: 1'b0};
        endcase
        return op;
    endfunction

    function automatic t_mac_op mac_op(input logic [4:0] step);
        t_mac_op op;
        case (step)
            5'd0:    op = '{A_S2_LO, B_N,  1'b0, 1'b1, ST_NONE};
            5'd1:    op = '{A_S2_HI, B_N,  1'b0, 1'b0, ST_NONE};
            5'd2:    op = '{A_SX,    B_SX, 1'b1, 1'b0, ST_NONE};
            5'd3:    op = '{A_SY,    B_SY, 1'b1, 1'b0, ST_DET};
            5'd4:    op = '{A_SD_LO, B_N,  1'b0, 1'b1, ST_NONE};
            5'd5:    op = '{A_SD_HI, B_N,  1'b0, 1'b0, ST_NONE};
            5'd6:    op = '{A_SX,    B_SU, 1'b1, 1'b0, ST_NONE};
            5'd7:    op = '{A_SY,    B_SV, 1'b1, 1'b0, ST_NA};
            5'd8:    op = '{A_SC_LO, B_N,  1'b0, 1'b1, ST_NONE};
            5'd9:    op = '{A_SC_HI, B_N,  1'b0, 1'b0, ST_NONE};
            5'd10:   op = '{A_SY,    B_SU, 1'b0, 1'b0, ST_NONE};
            5'd11:   op = '{A_SX,    B_SV, 1'b1, 1'b0, ST_NB};
            5'd12:   op = '{A_S2_LO, B_SU, 1'b0, 1'b1, ST_NONE};
            5'd13:   op = '{A_S2_HI, B_SU, 1'b0, 1'b0, ST_NONE};
            5'd14:   op = '{A_SD_LO, B_SX, 1'b1, 1'b0, ST_NONE};
            5'd15:   op = '{A_SD_HI, B_SX, 1'b1, 1'b0, ST_NONE};
            5'd16:   op = '{A_SC_LO, B_SY, 1'b0, 1'b0, ST_NONE};
            5'd17:   op = '{A_SC_HI, B_SY, 1'b0, 1'b0, ST_NX};
            5'd18:   op = '{A_S2_LO, B_SV, 1'b0, 1'b1, ST_NONE};
            5'd19:   op = '{A_S2_HI, B_SV, 1'b0, 1'b0, ST_NONE};
            5'd20:   op = '{A_SD_LO, B_SY, 1'b1, 1'b0, ST_NONE};
            5'd21:   op = '{A_SD_HI, B_SY, 1'b1, 1'b0, ST_NONE};
            5'd22:   op = '{A_SC_LO, B_SX, 1'b1, 1'b0, ST_NONE};
            5'd23:   op = '{A_SC_HI, B_SX, 1'b1, 1'b0, ST_NY};
            default: op = '{A_S2_LO, B_N,  1'b0, 1'b0, ST_NONE};
        endcase
        return op;
    endfunction

endpackage

[rtl/stf_div.sv]
module stf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [stf_pkg::ACC_W-1:0] i_num,
    input  logic [stf_pkg::DEN_W-1:0]       i_den,
    input  logic                            i_wide,
    output logic                            o_done,
    output logic signed [stf_pkg::SH_W-1:0] o_res
);

    logic                          r_busy;
    logic                          r_done;
    logic [stf_pkg::IT_W-1:0]      r_it;
    logic [stf_pkg::DVD_W-1:0]     r_dvd;
    logic [stf_pkg::REM_W-1:0]     r_rem;
    logic [stf_pkg::REM_W-1:0]     r_d2;
    logic [stf_pkg::Q_W-1:0]       r_q;
    logic                          r_ovf;
    logic                          r_neg;
    logic                          r_wide;

    logic [stf_pkg::ACC_W-1:0]     mag;
    logic [stf_pkg::DVD_W-1:0]     mag_ext;
    logic [stf_pkg::DVD_W-1:0]     dvd_init;
    logic [stf_pkg::REM_W-1:0]     rem_sh;
    logic                          ge;
    logic [stf_pkg::Q_W-1:0]       lim_pos;
    logic [stf_pkg::Q_W-1:0]       lim_neg;
    logic [stf_pkg::Q_W-1:0]       mag_sat;
    logic [stf_pkg::Q_W-1:0]       res_wide;

    always_comb begin
        mag      = i_num[stf_pkg::ACC_W-1] ? stf_pkg::ACC_W'(-i_num) : stf_pkg::ACC_W'(i_num);
        mag_ext  = stf_pkg::DVD_W'(mag);
        dvd_init = (i_wide ? (mag_ext << 13) : (mag_ext << 17)) + stf_pkg::DVD_W'(i_den);
        rem_sh   = {r_rem[stf_pkg::REM_W-2:0], r_dvd[stf_pkg::DVD_W-1]};
        ge       = (rem_sh >= r_d2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == stf_pkg::IT_W'(stf_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= dvd_init;
            r_rem  <= '0;
            r_d2   <= {1'b0, i_den, 1'b0};
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_neg  <= i_num[stf_pkg::ACC_W-1];
            r_wide <= i_wide;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= ge ? (rem_sh - r_d2) : rem_sh;
            r_q   <= {r_q[stf_pkg::Q_W-2:0], ge};
            r_ovf <= r_ovf | r_q[stf_pkg::Q_W-1];
        end
    end

    always_comb begin
        lim_pos = r_wide ? stf_pkg::Q_W'(33'h0_7FFF_FFFF) : stf_pkg::Q_W'(33'h0_007F_FFFF);
        lim_neg = lim_pos + 1'b1;
        if (r_neg) begin
            mag_sat  = (r_ovf || r_q > lim_neg) ? lim_neg : r_q;
            res_wide = -mag_sat;
        end else begin
            mag_sat  = (r_ovf || r_q > lim_pos) ? lim_pos : r_q;
            res_wide = mag_sat;
        end
    end

    assign o_done = r_done;
    assign o_res  = res_wide[stf_pkg::SH_W-1:0];

endmodule

[rtl/stf_datapath.sv]
module stf_datapath #(
    parameter int MAX_POINTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stf_pkg::t_cmd                      i_cmd,
    output stf_pkg::t_status                   o_status,
    input  logic signed [stf_pkg::IN_W-1:0]    i_src_x,
    input  logic signed [stf_pkg::IN_W-1:0]    i_src_y,
    input  logic signed [stf_pkg::IN_W-1:0]    i_dst_x,
    input  logic signed [stf_pkg::IN_W-1:0]    i_dst_y,
    output logic signed [stf_pkg::COS_W-1:0]   o_scale_cos,
    output logic signed [stf_pkg::COS_W-1:0]   o_scale_sin,
    output logic signed [stf_pkg::SH_W-1:0]    o_shift_x,
    output logic signed [stf_pkg::SH_W-1:0]    o_shift_y,
    output logic                               o_singular
);

    localparam int PC_W = $clog2(MAX_POINTS + 1);

    logic [PC_W-1:0]                     r_count;
    logic                                r_take;
    logic signed [stf_pkg::IN_W-1:0]     r_x, r_y, r_u, r_v;
    logic signed [stf_pkg::SUM_W-1:0]    r_sx, r_sy, r_su, r_sv;
    logic signed [stf_pkg::SQ_W-1:0]     r_s2, r_sd, r_sc;

    logic signed [stf_pkg::PRD_W-1:0]    r_pp;
    stf_pkg::t_prod_op                   r_pop;
    logic                                r_pv;

    logic signed [stf_pkg::MUL_W-1:0]    r_prod;
    stf_pkg::t_mac_op                    r_mop;
    logic                                r_mv;
    logic signed [stf_pkg::ACC_W-1:0]    r_acc;
    logic signed [stf_pkg::ACC_W-1:0]    r_det, r_na, r_nb, r_nx, r_ny;

    stf_pkg::t_didx                      r_didx;
    logic signed [stf_pkg::COS_W-1:0]    r_ra, r_rb;
    logic signed [stf_pkg::SH_W-1:0]     r_rx, r_ry;
    logic signed [stf_pkg::COS_W-1:0]    r_o_a, r_o_b;
    logic signed [stf_pkg::SH_W-1:0]     r_o_x, r_o_y;
    logic                                r_o_s;

    stf_pkg::t_prod_op                   pop;
    logic signed [stf_pkg::IN_W-1:0]     pa, pb;
    logic signed [stf_pkg::SQ_W-1:0]     pext;
    stf_pkg::t_mac_op                    mop;
    logic signed [stf_pkg::OPA_W-1:0]    ma, mb;
    logic signed [stf_pkg::ACC_W-1:0]    mext;
    logic signed [stf_pkg::ACC_W-1:0]    macc_base;
    logic signed [stf_pkg::ACC_W-1:0]    n_acc;
    logic signed [stf_pkg::ACC_W-1:0]    div_num;
    logic                                det_pos;
    logic                                div_done;
    logic signed [stf_pkg::SH_W-1:0]     div_res;

    always_comb begin
        pop = stf_pkg::prod_op(i_cmd.prod_idx);
        pa  = pop.a_y ? r_y : r_x;
        case (pop.b_sel)
            stf_pkg::PB_X: pb = r_x;
            stf_pkg::PB_Y: pb = r_y;
            stf_pkg::PB_U: pb = r_u;
            stf_pkg::PB_V: pb = r_v;
            default:       pb = r_x;
        endcase
        pext = stf_pkg::SQ_W'(r_pp);
    end

    always_comb begin
        mop = stf_pkg::mac_op(i_cmd.mac_step);
        case (mop.a_sel)
            stf_pkg::A_S2_LO: ma = {1'b0, r_s2[stf_pkg::LO_W-1:0]};
            stf_pkg::A_S2_HI: ma = stf_pkg::OPA_W'($signed(r_s2[stf_pkg::SQ_W-1:stf_pkg::LO_W]));
            stf_pkg::A_SD_LO: ma = {1'b0, r_sd[stf_pkg::LO_W-1:0]};
            stf_pkg::A_SD_HI: ma = stf_pkg::OPA_W'($signed(r_sd[stf_pkg::SQ_W-1:stf_pkg::LO_W]));
            stf_pkg::A_SC_LO: ma = {1'b0, r_sc[stf_pkg::LO_W-1:0]};
            stf_pkg::A_SC_HI: ma = stf_pkg::OPA_W'($signed(r_sc[stf_pkg::SQ_W-1:stf_pkg::LO_W]));
            stf_pkg::A_SX:    ma = stf_pkg::OPA_W'(r_sx);
            stf_pkg::A_SY:    ma = stf_pkg::OPA_W'(r_sy);
            default:          ma = '0;
        endcase
        case (mop.b_sel)
            stf_pkg::B_N:  mb = $signed({{(stf_pkg::OPA_W - PC_W){1'b0}}, r_count});
            stf_pkg::B_SX: mb = stf_pkg::OPA_W'(r_sx);
            stf_pkg::B_SY: mb = stf_pkg::OPA_W'(r_sy);
            stf_pkg::B_SU: mb = stf_pkg::OPA_W'(r_su);
            stf_pkg::B_SV: mb = stf_pkg::OPA_W'(r_sv);
            default:       mb = '0;
        endcase
    end

    always_comb begin
        mext = stf_pkg::ACC_W'(r_prod);
        if (r_mop.a_sel inside {stf_pkg::A_S2_HI, stf_pkg::A_SD_HI, stf_pkg::A_SC_HI}) begin
            mext = mext <<< stf_pkg::LO_W;
        end
        macc_base = r_mop.first ? '0 : r_acc;
        n_acc     = r_mop.sub ? (macc_base - mext) : (macc_base + mext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_su    <= '0;
            r_sv    <= '0;
            r_s2    <= '0;
            r_sd    <= '0;
            r_sc    <= '0;
            r_take  <= 1'b0;
            r_pv    <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            r_pv <= i_cmd.prod_en & r_take;
            r_mv <= i_cmd.mac_en;
            if (i_cmd.out_load) begin
                r_count <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_su    <= '0;
                r_sv    <= '0;
                r_s2    <= '0;
                r_sd    <= '0;
                r_sc    <= '0;
            end else begin
                if (i_cmd.load) begin
                    r_take <= (r_count < PC_W'(MAX_POINTS));
                    if (r_count < PC_W'(MAX_POINTS)) begin
                        r_count <= r_count + 1'b1;
                        r_sx    <= r_sx + stf_pkg::SUM_W'(i_src_x);
                        r_sy    <= r_sy + stf_pkg::SUM_W'(i_src_y);
                        r_su    <= r_su + stf_pkg::SUM_W'(i_dst_x);
                        r_sv    <= r_sv + stf_pkg::SUM_W'(i_dst_y);
                    end
                end
                if (r_pv) begin
                    case (r_pop.tgt)
                        stf_pkg::PT_NORM:  r_s2 <= r_pop.sub ? r_s2 - pext : r_s2 + pext;
                        stf_pkg::PT_DOT:   r_sd <= r_pop.sub ? r_sd - pext : r_sd + pext;
                        stf_pkg::PT_CROSS: r_sc <= r_pop.sub ? r_sc - pext : r_sc + pext;
                        default:           r_s2 <= r_s2;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_src_x;
            r_y <= i_src_y;
            r_u <= i_dst_x;
            r_v <= i_dst_y;
        end
        r_pp   <= pa * pb;
        r_pop  <= pop;
        r_prod <= ma * mb;
        r_mop  <= mop;
        if (r_mv) begin
            r_acc <= n_acc;
            case (r_mop.store)
                stf_pkg::ST_DET: r_det <= n_acc;
                stf_pkg::ST_NA:  r_na  <= n_acc;
                stf_pkg::ST_NB:  r_nb  <= n_acc;
                stf_pkg::ST_NX:  r_nx  <= n_acc;
                stf_pkg::ST_NY:  r_ny  <= n_acc;
                default:         r_det <= r_det;
            endcase
        end
        if (i_cmd.div_start) begin
            r_didx <= i_cmd.div_idx;
        end
        if (div_done) begin
            case (r_didx)
                stf_pkg::D_COS: r_ra <= div_res[stf_pkg::COS_W-1:0];
                stf_pkg::D_SIN: r_rb <= div_res[stf_pkg::COS_W-1:0];
                stf_pkg::D_SHX: r_rx <= div_res;
                stf_pkg::D_SHY: r_ry <= div_res;
                default:        r_ra <= r_ra;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_s <= !det_pos;
            r_o_a <= det_pos ? r_ra : '0;
            r_o_b <= det_pos ? r_rb : '0;
            r_o_x <= det_pos ? r_rx : '0;
            r_o_y <= det_pos ? r_ry : '0;
        end
    end

    always_comb begin
        det_pos = !r_det[stf_pkg::ACC_W-1] && (r_det != '0);
        case (i_cmd.div_idx)
            stf_pkg::D_COS: div_num = r_na;
            stf_pkg::D_SIN: div_num = r_nb;
            stf_pkg::D_SHX: div_num = r_nx;
            stf_pkg::D_SHY: div_num = r_ny;
            default:        div_num = r_na;
        endcase
    end

    stf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_det[stf_pkg::DEN_W-1:0]),
        .i_wide  (i_cmd.div_idx == stf_pkg::D_SHX || i_cmd.div_idx == stf_pkg::D_SHY),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    assign o_status.det_pos  = det_pos;
    assign o_status.div_done = div_done;
    assign o_scale_cos = r_o_a;
    assign o_scale_sin = r_o_b;
    assign o_shift_x   = r_o_x;
    assign o_shift_y   = r_o_y;
    assign o_singular  = r_o_s;

endmodule

[rtl/stf_ctrl.sv]
module stf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  stf_pkg::t_status i_status,
    output stf_pkg::t_cmd    o_cmd
);

    stf_pkg::t_state               r_state, n_state;
    logic [stf_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_last, n_last;
    logic                          r_ovalid, n_ovalid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        case (r_state)
            stf_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = stf_pkg::S_PROD;
                    n_cnt   = '0;
                    n_last  = i_last;
                end
            end
            stf_pkg::S_PROD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == stf_pkg::CNT_W'(stf_pkg::PROD_STEPS)) begin
                    n_cnt   = '0;
                    n_state = r_last ? stf_pkg::S_SOLVE : stf_pkg::S_IDLE;
                end
            end
            stf_pkg::S_SOLVE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == stf_pkg::CNT_W'(stf_pkg::SOLVE_STEPS)) begin
                    n_cnt   = '0;
                    n_state = i_status.det_pos ? stf_pkg::S_DIV : stf_pkg::S_OUT;
                end
            end
            stf_pkg::S_DIV: begin
                n_state = stf_pkg::S_DWAIT;
            end
            stf_pkg::S_DWAIT: begin
                if (i_status.div_done) begin
                    if (r_cnt == stf_pkg::CNT_W'(stf_pkg::DIV_COUNT - 1)) begin
                        n_state = stf_pkg::S_OUT;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = stf_pkg::S_DIV;
                    end
                end
            end
            stf_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = stf_pkg::S_IDLE;
                end
            end
            default: n_state = stf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.prod_idx  = r_cnt[2:0];
        o_cmd.mac_step  = r_cnt[4:0];
        o_cmd.div_idx   = stf_pkg::t_didx'(r_cnt[1:0]);
        o_ready         = 1'b0;
        case (r_state)
            stf_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            stf_pkg::S_PROD: begin
                o_cmd.prod_en = (r_cnt < stf_pkg::CNT_W'(stf_pkg::PROD_STEPS));
            end
            stf_pkg::S_SOLVE: begin
                o_cmd.mac_en = (r_cnt < stf_pkg::CNT_W'(stf_pkg::SOLVE_STEPS));
            end
            stf_pkg::S_DIV: begin
                o_cmd.div_start = 1'b1;
            end
            stf_pkg::S_OUT: begin
                o_cmd.out_load = !r_ovalid || i_ready;
            end
            default: o_ready = 1'b0;
        endcase
        n_ovalid = o_cmd.out_load ? 1'b1 : (r_ovalid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stf_pkg::S_IDLE;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    a_solve_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stf_pkg::S_SOLVE && r_cnt == stf_pkg::CNT_W'(stf_pkg::SOLVE_STEPS))
        |=> (r_state == stf_pkg::S_DIV || r_state == stf_pkg::S_OUT))
        else $error("solve did not end in divide or output");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || i_ready))
        else $error("output overwritten while held");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == stf_pkg::S_DWAIT))
        else $error("divider done outside wait");

    a_prod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stf_pkg::S_PROD && r_cnt == stf_pkg::CNT_W'(stf_pkg::PROD_STEPS) && !r_last)
        |=> (r_state == stf_pkg::S_IDLE))
        else $error("non-final item did not return to idle");

endmodule

[rtl/similarity_transform_fit.sv]
// Least-squares 2D similarity fit: u = a*x - b*y + tx, v = b*x + a*y + ty.
// Input channel (i_valid / o_ready): one source/target point pair per item,
// Q12.4 coordinates; i_last marks the final pair of a set. Pairs beyond
// MAX_POINTS are dropped, but a last pair still starts the solve.
// Output channel (o_valid / i_ready): one result per set, a and b in Q8.16,
// tx and ty in Q16.16, saturated; singular set gives zeros with o_singular.
// Each pair is accepted in the idle state and then occupies the block while
// a single 16x16 multiplier builds the squared and cross sums. A last pair
// then drives one 25x25 multiply-accumulate unit forming the determinant
// and four numerators, and the bit-serial divider for the four quotients
// (one quotient bit per cycle, 78 bits per quotient); a singular set skips
// the divider. The result sits in an output register; new pairs are
// accepted while it waits. A stalled receiver only holds the next set's
// solve at its output step. Reset clears all sums, the count and the
// output valid.
module similarity_transform_fit #(
    parameter int MAX_POINTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [stf_pkg::IN_W-1:0]  i_src_x,
    input  logic signed [stf_pkg::IN_W-1:0]  i_src_y,
    input  logic signed [stf_pkg::IN_W-1:0]  i_dst_x,
    input  logic signed [stf_pkg::IN_W-1:0]  i_dst_y,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [stf_pkg::COS_W-1:0] o_scale_cos,
    output logic signed [stf_pkg::COS_W-1:0] o_scale_sin,
    output logic signed [stf_pkg::SH_W-1:0]  o_shift_x,
    output logic signed [stf_pkg::SH_W-1:0]  o_shift_y,
    output logic                             o_singular
);

    stf_pkg::t_cmd    cmd;
    stf_pkg::t_status status;

    stf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_src_x     (i_src_x),
        .i_src_y     (i_src_y),
        .i_dst_x     (i_dst_x),
        .i_dst_y     (i_dst_y),
        .o_scale_cos (o_scale_cos),
        .o_scale_sin (o_scale_sin),
        .o_shift_x   (o_shift_x),
        .o_shift_y   (o_shift_y),
        .o_singular  (o_singular)
    );

endmodule

[tb/similarity_transform_fit_test.sv]
`timescale 1ns / 1ps

module similarity_transform_fit_test;

    localparam int MAX_POINTS = 8;

    typedef struct {
        bit                 drain;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               last;
    } t_pair;

    typedef struct {
        logic signed [23:0] cos_q;
        logic signed [23:0] sin_q;
        logic signed [31:0] shx;
        logic signed [31:0] shy;
        logic               sing;
    } t_fit;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_src_x;
    logic signed [15:0] i_src_y;
    logic signed [15:0] i_dst_x;
    logic signed [15:0] i_dst_y;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic signed [23:0] o_scale_cos;
    logic signed [23:0] o_scale_sin;
    logic signed [31:0] o_shift_x;
    logic signed [31:0] o_shift_y;
    logic               o_singular;

    similarity_transform_fit #(.MAX_POINTS(MAX_POINTS)) i_dut (.*);

    t_pair pending_pairs[$];
    t_fit  expected_fits[$];
    int    pairs_taken;
    int    fits_checked;
    int    singular_fits;
    int    mismatches;
    bit    rx_hold;

    longint pts, s_x, s_y, s_u, s_v, s_norm, s_dot, s_cross;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic bit calm();
        return pairs_taken >= 300 && pairs_taken < 400;
    endfunction

    function automatic longint round_div(longint num, longint den, int k,
                                         longint lo, longint hi);
        longint unsigned mag, q, r, frac;
        longint          s;
        mag = num < 0 ? -num : num;
        q   = mag / den;
        r   = mag % den;
        if (q > (64'd1 << 40))
            q = 64'd1 << 40;
        frac = (((r << k) << 1) + den) / (den << 1);
        s    = longint'((q << k) + frac);
        if (num < 0)
            s = -s;
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        return s;
    endfunction

    task automatic fit_pair(t_pair p);
        longint x, y, u, v, det, na, nb, nx, ny;
        t_fit   f;
        x = p.sx;
        y = p.sy;
        u = p.dx;
        v = p.dy;
        if (pts < MAX_POINTS) begin
            pts++;
            s_x += x;
            s_y += y;
            s_u += u;
            s_v += v;
            s_norm  += x * x + y * y;
            s_dot   += x * u + y * v;
            s_cross += x * v - y * u;
        end
        if (!p.last)
            return;
        f   = '{0, 0, 0, 0, 1'b0};
        det = pts * s_norm - s_x * s_x - s_y * s_y;
        if (det <= 0) begin
            f.sing = 1'b1;
        end else begin
            na = pts * s_dot - s_x * s_u - s_y * s_v;
            nb = pts * s_cross + s_y * s_u - s_x * s_v;
            nx = s_norm * s_u - s_x * s_dot + s_y * s_cross;
            ny = s_norm * s_v - s_y * s_dot - s_x * s_cross;
            f.cos_q = 24'(round_div(na, det, 16, -8388608, 8388607));
            f.sin_q = 24'(round_div(nb, det, 16, -8388608, 8388607));
            f.shx   = 32'(round_div(nx, det, 12, -64'sd2147483648, 64'sd2147483647));
            f.shy   = 32'(round_div(ny, det, 12, -64'sd2147483648, 64'sd2147483647));
        end
        expected_fits = {expected_fits, f};
        {pts, s_x, s_y, s_u, s_v, s_norm, s_dot, s_cross} = '0;
    endtask

    always @(posedge i_clk) begin
        t_pair p;
        logic  nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                fit_pair('{0, i_src_x, i_src_y, i_dst_x, i_dst_y, i_last});
                pairs_taken++;
            end
            if (!i_valid || o_ready) begin
                nv = 1'b0;
                if (pending_pairs.size() > 0 && pending_pairs[0].drain
                        && expected_fits.size() == 0)
                    void'(pending_pairs.pop_front());
                if (pending_pairs.size() > 0 && !pending_pairs[0].drain
                        && (calm() || $urandom_range(0, 99) >= 22)) begin
                    p = pending_pairs.pop_front();
                    i_src_x <= p.sx;
                    i_src_y <= p.sy;
                    i_dst_x <= p.dx;
                    i_dst_y <= p.dy;
                    i_last  <= p.last;
                    nv = 1'b1;
                end
                i_valid <= nv;
            end
        end
    end

    always @(posedge i_clk) begin
        t_fit f;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_fits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: cos %0d sin %0d", o_scale_cos,
                                 o_scale_sin);
                end else begin
                    f = expected_fits.pop_front();
                    fits_checked++;
                    singular_fits += f.sing;
                    if (o_scale_cos !== f.cos_q || o_scale_sin !== f.sin_q
                            || o_shift_x !== f.shx || o_shift_y !== f.shy
                            || o_singular !== f.sing) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"fit %0d mismatch: exp %0d %0d %0d %0d %0b",
                                      " got %0d %0d %0d %0d %0b"}, fits_checked,
                                     f.cos_q, f.sin_q, f.shx, f.shy, f.sing,
                                     o_scale_cos, o_scale_sin, o_shift_x, o_shift_y,
                                     o_singular);
                    end
                end
            end
            i_ready <= !rx_hold && (calm() || $urandom_range(0, 99) >= 22);
        end
    end

    task automatic add_pair(int sx, int sy, int dx, int dy, bit last);
        pending_pairs = {pending_pairs,
                         t_pair'{0, 16'(sx), 16'(sy), 16'(dx), 16'(dy), last}};
    endtask

    function automatic int clamp16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    task automatic add_random_set();
        int n, kind, span, a, b, x, y, tx, ty, noise;
        n    = $urandom_range(0, 9) == 0 ? $urandom_range(9, 12) : $urandom_range(1, 8);
        kind = $urandom_range(0, 9);
        span = kind == 1 ? 1 : ($urandom_range(0, 1) ? 32767 : $urandom_range(16, 4000));
        x    = $urandom_range(0, 65535) - 32768;
        y    = $urandom_range(0, 65535) - 32768;
        a    = $urandom_range(0, 8192) - 4096;
        b    = $urandom_range(0, 8192) - 4096;
        tx   = $urandom_range(0, 8000) - 4000;
        ty   = $urandom_range(0, 8000) - 4000;
        noise = $urandom_range(0, 64);
        for (int i = 0; i < n; i++) begin
            int px, py;
            if (kind == 0) begin
                px = x;
                py = y;
            end else begin
                px = clamp16(x + $urandom_range(0, 2 * span) - span);
                py = clamp16(y + $urandom_range(0, 2 * span) - span);
                if (kind > 2) begin
                    px = px / 4;
                    py = py / 4;
                end
            end
            if (kind <= 2)
                add_pair(px, py, $urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768, i == n - 1);
            else
                add_pair(px, py,
                         clamp16((a * px - b * py) / 4096 + tx
                                 + $urandom_range(0, 2 * noise) - noise),
                         clamp16((b * px + a * py) / 4096 + ty
                                 + $urandom_range(0, 2 * noise) - noise),
                         i == n - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_src_x, i_src_y, i_dst_x, i_dst_y, i_last} = '0;
        rx_hold = 1'b0;
        pairs_taken = 0;
        fits_checked = 0;
        singular_fits = 0;
        mismatches = 0;
        {pts, s_x, s_y, s_u, s_v, s_norm, s_dot, s_cross} = '0;

        // single point, coincident extremes, empty-range set
        add_pair(100, -200, 5, 7, 1);
        add_pair(-32768, -32768, 32767, -32768, 0);
        add_pair(-32768, -32768, -32768, 32767, 1);
        add_pair(0, 0, 0, 0, 1);
        // widest spread with extreme targets
        add_pair(-32768, -32768, 32767, 32767, 0);
        add_pair(32767, 32767, -32768, -32768, 0);
        add_pair(-32768, 32767, -32768, 32767, 0);
        add_pair(32767, -32768, 32767, -32768, 1);
        // nearly coincident points drive saturation
        add_pair(0, 0, -32768, 32767, 0);
        add_pair(1, 0, 32767, -32768, 1);
        add_pair(32767, 32767, 32767, 32767, 0);
        add_pair(32767, 32766, -32768, -32768, 1);
        // overfull set: pairs past the limit are dropped
        for (int i = 0; i < 11; i++)
            add_pair(i * 64, -i * 32, i * 48 + 7, i * 16 - 3, i == 10);
        pending_pairs = {pending_pairs, t_pair'{1, 0, 0, 0, 0, 0}};
        while (pending_pairs.size() < 620) begin
            add_random_set();
            if ($urandom_range(0, 29) == 0)
                pending_pairs = {pending_pairs, t_pair'{1, 0, 0, 0, 0, 0}};
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        wait (pairs_taken >= 150);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (3000) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        wait (pending_pairs.size() == 0 && !i_valid && expected_fits.size() == 0);
        repeat (500) @(posedge i_clk);
        $display("pairs accepted %0d, fits checked %0d (%0d singular)", pairs_taken,
                 fits_checked, singular_fits);
        $display("mismatches %0d, fits still owed %0d", mismatches, expected_fits.size());
        if (mismatches == 0 && expected_fits.size() == 0)
            $display("similarity_transform_fit regression: pass");
        else
            $display("similarity_transform_fit regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout after %0d pairs", pairs_taken);
        $display("similarity_transform_fit regression: fail");
        $finish;
    end

endmodule
